// ----- sv/ipv4_header_builder_defines.svh -----
// ----------------------------------------------------------------------------
// ipv4_header_builder_defines
// assertion macros shared by the header builder rtl
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_BUILDER_DEFINES_SVH
`define IPV4_HEADER_BUILDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IHB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IHB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ihb_pkg.sv -----
// ----------------------------------------------------------------------------
// ihb_pkg
// types and fixed constants of the ipv4 header builder
// ----------------------------------------------------------------------------
package ihb_pkg;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // header geometry
   localparam logic [3:0] BASE_WORDS = 4'd5;
   localparam logic [7:0] BASE_BYTES = 8'd20;

   // limit register reset value
   localparam logic [7:0] LIMIT_RESET = 8'd60;

   // checksum accumulator: up to 30 halves of 16 bits
   localparam int SUM_W = 21;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_FOLD,
      ST_EMIT
   } state_type;

endpackage

// ----- sv/ipv4_header_builder.sv -----
// ----------------------------------------------------------------------------
// ipv4_header_builder
// builds an ipv4 header as 32-bit words with a recomputed header checksum
// ----------------------------------------------------------------------------
// channel   ports              transfer
// request   start/busy, req_*  start high while busy low
// response  rsp_valid, rsp_*   one word per cycle, no back-pressure
// config    csr_wr_en/data     any cycle with csr_wr_en high
//
// a load does not make the block busy; an error result comes in the cycle after the emit.
// an emit of n words (5 to 15) holds busy while the single read port of the
// option memory is swept once to sum the checksum, then again to send the
// words, one word a cycle.
// reset is synchronous; it clears the per-entry valid bits of the option
// memory, so there is no clearing pass. results cannot be stalled.
// ----------------------------------------------------------------------------
`include "ipv4_header_builder_defines.svh"

module ipv4_header_builder #(
   parameter int MAX_OPTION_WORDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [3:0]  req_opt_index,
   input  logic [31:0] req_opt_word,
   input  logic [7:0]  req_version_ihl,
   input  logic [7:0]  req_tos,
   input  logic [15:0] req_total_length,
   input  logic [15:0] req_ident,
   input  logic [15:0] req_flags_fragment,
   input  logic [7:0]  req_ttl,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_word,
   output logic [3:0]  rsp_word_index,
   output logic        rsp_last,
   output logic        rsp_error,
   output logic [15:0] rsp_header_checksum
);

   localparam int IDX_W = (MAX_OPTION_WORDS > 1) ? $clog2(MAX_OPTION_WORDS) : 1;
   localparam logic [3:0] MAX_W4 = 4'(MAX_OPTION_WORDS);

   // control state
   ihb_pkg::state_type state_ff, state_in;
   logic [7:0]  limit_ff;
   logic        opt_ff, opt_in;
   logic [MAX_OPTION_WORDS-1:0] vld_ff;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        pv_ff, pv_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [31:0] base_ff [5];
   logic [31:0] base_in [5];
   logic        base_we;
   logic [ihb_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [15:0] csum_ff, csum_in;
   logic [3:0]  pidx_ff;
   logic        pok_ff;
   logic [31:0] rd_data_ff;
   logic        rd_vld_ff;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_error_ff, rsp_error_in;
   logic [15:0] rsp_csum_ff, rsp_csum_in;

   // option memory
   logic [31:0] mem [MAX_OPTION_WORDS];

   logic             go;
   logic             wr_en;
   logic [IDX_W-1:0] waddr;
   logic [IDX_W-1:0] raddr;
   logic             issue;
   logic [3:0]       slot_a;
   logic             slot_ok;
   logic             err;
   logic [3:0]       ihl;
   logic [3:0]       nopt;
   logic [31:0]      cur_word;
   logic [16:0]      fold1;
   logic [15:0]      fold2;

   assign busy = (state_ff != ihb_pkg::ST_IDLE);
   assign go   = start && !busy;
   assign ihl  = req_version_ihl[3:0];

   // limit check on the requested header length
   assign err = (limit_ff < ihb_pkg::BASE_BYTES) || ({2'b00, ihl, 2'b00} > limit_ff);
   assign nopt = (opt_ff && (ihl > ihb_pkg::BASE_WORDS)) ? (ihl - ihb_pkg::BASE_WORDS) : 4'd0;

   // option write on a load transfer
   assign wr_en = go && (req_cmd == ihb_pkg::CMD_LOAD) && (req_opt_index < MAX_W4);
   assign waddr = req_opt_index[IDX_W-1:0];

   // read issue: one word position per cycle while sweeping
   assign issue   = ((state_ff == ihb_pkg::ST_SUM) || (state_ff == ihb_pkg::ST_EMIT))
                    && (idx_ff != cnt_ff);
   assign slot_a  = idx_ff - ihb_pkg::BASE_WORDS;
   assign slot_ok = (idx_ff >= ihb_pkg::BASE_WORDS) && (slot_a < MAX_W4);
   assign raddr   = slot_ok ? slot_a[IDX_W-1:0] : '0;

   // word at the read stage: base register, option memory data, or zero
   always_comb begin
      if (pidx_ff < ihb_pkg::BASE_WORDS) begin
         cur_word = base_ff[pidx_ff[2:0]];
      end else if (pok_ff && rd_vld_ff) begin
         cur_word = rd_data_ff;
      end else begin
         cur_word = '0;
      end
   end

   // end-around fold of the accumulated sum
   assign fold1 = 17'(acc_ff[ihb_pkg::SUM_W-1:16]) + 17'(acc_ff[15:0]);
   assign fold2 = 16'(fold1[16]) + fold1[15:0];

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      opt_in       = opt_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pv_in        = issue;
      acc_in       = acc_ff;
      csum_in      = csum_ff;
      base_we      = 1'b0;
      base_in[0]   = {req_version_ihl, req_tos, req_total_length};
      base_in[1]   = {req_ident, req_flags_fragment};
      base_in[2]   = {req_ttl, req_protocol, 16'h0000};
      base_in[3]   = req_src_addr;
      base_in[4]   = req_dst_addr;
      rsp_valid_in = 1'b0;
      rsp_word_in  = '0;
      rsp_index_in = '0;
      rsp_last_in  = 1'b0;
      rsp_error_in = 1'b0;
      rsp_csum_in  = '0;
      if (issue) begin
         idx_in = idx_ff + 4'd1;
      end
      case (state_ff)
         ihb_pkg::ST_IDLE: begin
            if (wr_en) begin
               opt_in = 1'b1;
            end
            if (go && (req_cmd == ihb_pkg::CMD_EMIT)) begin
               if (err) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b1;
               end else begin
                  base_we  = 1'b1;
                  idx_in   = '0;
                  cnt_in   = ihb_pkg::BASE_WORDS + nopt;
                  acc_in   = '0;
                  state_in = ihb_pkg::ST_SUM;
               end
            end
         end
         ihb_pkg::ST_SUM: begin
            if (pv_ff) begin
               acc_in = acc_ff + ihb_pkg::SUM_W'(cur_word[31:16])
                        + ihb_pkg::SUM_W'(cur_word[15:0]);
            end
            if (idx_ff == cnt_ff) begin
               state_in = ihb_pkg::ST_FOLD;
            end
         end
         ihb_pkg::ST_FOLD: begin
            csum_in  = ~fold2;
            idx_in   = '0;
            state_in = ihb_pkg::ST_EMIT;
         end
         ihb_pkg::ST_EMIT: begin
            if (pv_ff) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = (pidx_ff == 4'd2) ? (cur_word | {16'h0000, csum_ff}) : cur_word;
               rsp_index_in = pidx_ff;
               rsp_last_in  = (pidx_ff == (cnt_ff - 4'd1));
               rsp_csum_in  = csum_ff;
            end
            if (idx_ff == cnt_ff) begin
               state_in = ihb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ihb_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ihb_pkg::ST_IDLE;
         limit_ff     <= ihb_pkg::LIMIT_RESET;
         opt_ff       <= 1'b0;
         vld_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= ihb_pkg::BASE_WORDS;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opt_ff       <= opt_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (wr_en) begin
            vld_ff[waddr] <= 1'b1;
         end
      end
   end

   // option memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= req_opt_word;
      end
      rd_data_ff <= mem[raddr];
      rd_vld_ff  <= vld_ff[raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (base_we) begin
         for (int i = 0; i < 5; i++) begin
            base_ff[i] <= base_in[i];
         end
      end
      acc_ff       <= acc_in;
      csum_ff      <= csum_in;
      pidx_ff      <= idx_ff;
      pok_ff       <= slot_ok;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
      rsp_csum_ff  <= rsp_csum_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_word        = rsp_word_ff;
   assign rsp_word_index      = rsp_index_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_error           = rsp_error_ff;
   assign rsp_header_checksum = rsp_csum_ff;

   // checks
   `IHB_ASSERT_SAME(a_err_last, clock, reset, rsp_valid && rsp_error, rsp_last && !busy, "error result must be last and leave the block idle")
   `IHB_ASSERT_NEXT(a_emit_busy, clock, reset, go && (req_cmd == ihb_pkg::CMD_EMIT) && !err, busy, "emit transfer must start a sweep")
   `IHB_ASSERT_SAME(a_last_index, clock, reset, rsp_valid && rsp_last && !rsp_error, rsp_word_index == (cnt_ff - 4'd1), "last word index must match word count")
   `IHB_ASSERT_SAME(a_read_stage, clock, reset, pv_ff, (state_ff == ihb_pkg::ST_SUM) || (state_ff == ihb_pkg::ST_EMIT), "read stage active outside a sweep")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the ipv4 header builder word by word against a behavioral model of
// the header layout, option words, checksum and limit error, with bursty
// request timing and a sweep of limit register settings
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPT_SLOTS     = 10;
   localparam int MAX_HDR_WORDS = 15;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      logic        cmd;
      logic [3:0]  opt_index;
      logic [31:0] opt_word;
      logic [7:0]  version_ihl;
      logic [7:0]  tos;
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [15:0] flags_fragment;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } hdr_request_type;

   typedef struct {
      logic [31:0] word;
      logic [3:0]  index;
      logic        last;
      logic        error;
      logic [15:0] checksum;
   } hdr_word_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic        busy;
   logic        req_cmd            = 1'b0;
   logic [3:0]  req_opt_index      = '0;
   logic [31:0] req_opt_word       = '0;
   logic [7:0]  req_version_ihl    = '0;
   logic [7:0]  req_tos            = '0;
   logic [15:0] req_total_length   = '0;
   logic [15:0] req_ident          = '0;
   logic [15:0] req_flags_fragment = '0;
   logic [7:0]  req_ttl            = '0;
   logic [7:0]  req_protocol       = '0;
   logic [31:0] req_src_addr       = '0;
   logic [31:0] req_dst_addr       = '0;
   logic        csr_wr_en          = 1'b0;
   logic [7:0]  csr_wr_data        = '0;
   logic        rsp_valid;
   logic [31:0] rsp_out_word;
   logic [3:0]  rsp_word_index;
   logic        rsp_last;
   logic        rsp_error;
   logic [15:0] rsp_header_checksum;

   // stimulus and expectation stores
   hdr_request_type request_queue[$];
   hdr_word_type    expected_words[$];
   hdr_request_type held_req;

   // shadow copy of the block state
   logic [31:0] opt_shadow [OPT_SLOTS];
   bit          opt_loaded;
   logic [7:0]  limit_shadow;

   bit          holding;
   int          burst_left;
   int          gap_left;
   int          fail_count;
   int          cycle_count;
   int          headers_built;
   int          errors_expected;
   int          loads_taken;
   int          words_checked;
   logic [7:0]  mid_limit;

   ipv4_header_builder #(
      .MAX_OPTION_WORDS(OPT_SLOTS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_opt_index      (req_opt_index),
      .req_opt_word       (req_opt_word),
      .req_version_ihl    (req_version_ihl),
      .req_tos            (req_tos),
      .req_total_length   (req_total_length),
      .req_ident          (req_ident),
      .req_flags_fragment (req_flags_fragment),
      .req_ttl            (req_ttl),
      .req_protocol       (req_protocol),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_out_word       (rsp_out_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last           (rsp_last),
      .rsp_error          (rsp_error),
      .rsp_header_checksum(rsp_header_checksum)
   );

   always #6 clock = ~clock;

   // header prediction: option loads update the shadow store, emits queue words
   task automatic build_header(input hdr_request_type r);
      logic [31:0]  hw [MAX_HDR_WORDS];
      hdr_word_type w;
      int           n_words;
      int           hlen;
      logic [31:0]  sum;
      logic [15:0]  csum;
      if (r.cmd == ihb_pkg::CMD_LOAD) begin
         if (r.opt_index < OPT_SLOTS) begin
            opt_shadow[r.opt_index] = r.opt_word;
            opt_loaded = 1'b1;
            loads_taken++;
         end
      end else begin
         hlen = r.version_ihl[3:0] * 4;
         if (limit_shadow < ihb_pkg::BASE_BYTES || hlen > limit_shadow) begin
            // limit error: one zeroed word flagged last and error
            w.word     = '0;
            w.index    = '0;
            w.last     = 1'b1;
            w.error    = 1'b1;
            w.checksum = '0;
            expected_words.push_back(w);
            errors_expected++;
         end else begin
            hw[0] = {r.version_ihl, r.tos, r.total_length};
            hw[1] = {r.ident, r.flags_fragment};
            hw[2] = {r.ttl, r.protocol, 16'h0000};
            hw[3] = r.src_addr;
            hw[4] = r.dst_addr;
            n_words = ihb_pkg::BASE_WORDS;
            // option words only once something was loaded
            if (opt_loaded && hlen > ihb_pkg::BASE_BYTES) begin
               for (int k = 0; k < (hlen - ihb_pkg::BASE_BYTES) / 4
                               && n_words < MAX_HDR_WORDS; k++) begin
                  hw[n_words] = (k < OPT_SLOTS) ? opt_shadow[k] : '0;
                  n_words++;
               end
            end
            // ones-complement sum with end-around carry
            sum = '0;
            for (int k = 0; k < n_words; k++)
               sum += hw[k][31:16] + hw[k][15:0];
            while (sum[31:16] != 0)
               sum = sum[31:16] + sum[15:0];
            csum = ~sum[15:0];
            hw[2][15:0] = csum;
            for (int k = 0; k < n_words; k++) begin
               w.word     = hw[k];
               w.index    = 4'(k);
               w.last     = (k == n_words - 1);
               w.error    = 1'b0;
               w.checksum = csum;
               expected_words.push_back(w);
            end
            headers_built++;
         end
      end
   endtask

   // request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
         foreach (opt_shadow[i])
            opt_shadow[i] = '0;
         opt_loaded = 1'b0;
         limit_shadow = ihb_pkg::LIMIT_RESET;
      end else begin
         if (csr_wr_en)
            limit_shadow = csr_wr_data;
         // transfer taken at this edge
         if (start && !busy) begin
            build_header(held_req);
            holding = 1'b0;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                          $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
            end
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() != 0) begin
               held_req = request_queue.pop_front();
               holding = 1'b1;
               req_cmd            <= held_req.cmd;
               req_opt_index      <= held_req.opt_index;
               req_opt_word       <= held_req.opt_word;
               req_version_ihl    <= held_req.version_ihl;
               req_tos            <= held_req.tos;
               req_total_length   <= held_req.total_length;
               req_ident          <= held_req.ident;
               req_flags_fragment <= held_req.flags_fragment;
               req_ttl            <= held_req.ttl;
               req_protocol       <= held_req.protocol;
               req_src_addr       <= held_req.src_addr;
               req_dst_addr       <= held_req.dst_addr;
            end
         end
         start <= holding;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result monitor: every strobed word is compared with the oldest expectation
   always @(posedge clock) begin : monitor
      hdr_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h index %0d last %b error %b checksum %h",
                     $time, rsp_out_word, rsp_word_index, rsp_last, rsp_error,
                     rsp_header_checksum);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("out_word", want.word, rsp_out_word);
            check_field("word_index", want.index, rsp_word_index);
            check_field("last", want.last, rsp_last);
            check_field("error", want.error, rsp_error);
            check_field("header_checksum", want.checksum, rsp_header_checksum);
            words_checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic hdr_request_type rand_request(input logic cmd);
      hdr_request_type r;
      r.cmd            = cmd;
      r.opt_index      = 4'($urandom_range(0, OPT_SLOTS - 1));
      r.opt_word       = pick_word();
      // mostly version 4 with a legal length, sometimes any byte
      r.version_ihl    = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                         {4'd4, 4'($urandom_range(5, 15))};
      r.tos            = 8'(pick_word());
      r.total_length   = 16'(pick_word());
      r.ident          = 16'(pick_word());
      r.flags_fragment = 16'(pick_word());
      r.ttl            = 8'(pick_word());
      r.protocol       = 8'(pick_word());
      r.src_addr       = pick_word();
      r.dst_addr       = pick_word();
      return r;
   endfunction

   // quiet block: nothing queued, held, in flight or expected, then a short pause
   task automatic wait_idle();
      do
         @(posedge clock);
      while (request_queue.size() != 0 || holding || start || busy
             || expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // option loads followed by an emit, with stray out-of-range loads as noise
   task automatic random_traffic(input int n);
      hdr_request_type r;
      int              made;
      made = 0;
      while (made < n) begin
         repeat ($urandom_range(0, 3)) begin
            r = rand_request(ihb_pkg::CMD_LOAD);
            if ($urandom_range(0, 7) == 0)
               r.opt_index = 4'($urandom_range(OPT_SLOTS, 15));
            else
               made++;
            request_queue.push_back(r);
         end
         request_queue.push_back(rand_request(ihb_pkg::CMD_EMIT));
         made++;
      end
   endtask

   initial begin
      hdr_request_type r;
      logic [7:0]      short_lengths [4];

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // nothing loaded yet: a long header length still gives the base words
      r = rand_request(ihb_pkg::CMD_EMIT);
      r.version_ihl = 8'h4f;
      request_queue.push_back(r);
      // all fields zero, then all ones
      r = '{default: '0};
      r.cmd = ihb_pkg::CMD_EMIT;
      request_queue.push_back(r);
      r = '{default: '1};
      request_queue.push_back(r);
      // loads to slots past the store are dropped and set nothing
      r = rand_request(ihb_pkg::CMD_LOAD);
      r.opt_index = 4'd10;
      request_queue.push_back(r);
      r.opt_index = 4'hf;
      request_queue.push_back(r);
      r = rand_request(ihb_pkg::CMD_EMIT);
      r.version_ihl = 8'h4f;
      request_queue.push_back(r);
      // fill every option slot, extremes first
      for (int i = 0; i < OPT_SLOTS; i++) begin
         r = rand_request(ihb_pkg::CMD_LOAD);
         r.opt_index = 4'(i);
         r.opt_word  = (i == 0) ? 32'hffff_ffff : (i == 1) ? 32'h0 : $urandom;
         request_queue.push_back(r);
      end
      // one option word, all ten, and short header lengths
      short_lengths = '{8'h46, 8'h4f, 8'h44, 8'h40};
      foreach (short_lengths[i]) begin
         r = rand_request(ihb_pkg::CMD_EMIT);
         r.version_ihl = short_lengths[i];
         request_queue.push_back(r);
      end
      // stray load with options present must not disturb the store
      r = rand_request(ihb_pkg::CMD_LOAD);
      r.opt_index = 4'd12;
      request_queue.push_back(r);
      r = rand_request(ihb_pkg::CMD_EMIT);
      r.version_ihl = 8'h4f;
      request_queue.push_back(r);

      // limit sweep with random traffic in each setting
      mid_limit = 8'($urandom_range(21, 59));
      write_limit(8'd0);
      random_traffic(40);
      write_limit(8'd19);
      random_traffic(30);
      write_limit(8'd20);
      random_traffic(50);
      write_limit(8'd255);
      random_traffic(60);
      write_limit(mid_limit);
      random_traffic(60);
      write_limit(ihb_pkg::LIMIT_RESET);
      random_traffic(60);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d headers, %0d limit errors and %0d option loads",
               headers_built, errors_expected, loads_taken);
      $display("%0d words checked; limits used: 60, 0, 19, 20, 255, %0d, then 60 again",
               words_checked, mid_limit);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
